@@ rtl/two_grain_pitch_shifter_assert.svh @@
// Assertion macros used by the pitch shifter checker.
`ifndef TWO_GRAIN_PITCH_SHIFTER_ASSERT_SVH
`define TWO_GRAIN_PITCH_SHIFTER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define TGPS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define TGPS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/tgps_pkg.sv @@
// Package: constants, widths and the Hann window table of the pitch shifter.
package tgps_pkg;

   localparam int BUFFER_DEPTH_DEF = 2048;
   localparam int GRAIN_LENGTH_DEF = 1024;

   localparam int SAMPLE_W    = 24;
   localparam int RATIO_W     = 16;
   localparam int MIX_W       = 16;
   localparam int COEF_W      = 16;
   localparam int REQ_TDATA_W = 56;
   localparam int RSP_TDATA_W = 24;

   localparam logic [COEF_W-1:0]  COEF_RESET    = 16'd65263;
   localparam logic [RATIO_W-1:0] RATIO_UNITY   = 16'd16384;
   localparam logic [MIX_W-1:0]   MIX_FULL      = 16'd32768;
   localparam logic [MIX_W-1:0]   MIX_THRESHOLD = 16'd4;

   // Half of a 65-point Hann window in Q1.16, points 0 to 32.
   function automatic logic [16:0] hann_half(input logic [5:0] i);
      logic [16:0] v;
      case (i)
         6'd0:  v = 17'd0;
         6'd1:  v = 17'd158;
         6'd2:  v = 17'd630;
         6'd3:  v = 17'd1411;
         6'd4:  v = 17'd2494;
         6'd5:  v = 17'd3869;
         6'd6:  v = 17'd5522;
         6'd7:  v = 17'd7438;
         6'd8:  v = 17'd9598;
         6'd9:  v = 17'd11980;
         6'd10: v = 17'd14563;
         6'd11: v = 17'd17321;
         6'd12: v = 17'd20228;
         6'd13: v = 17'd23256;
         6'd14: v = 17'd26375;
         6'd15: v = 17'd29556;
         6'd16: v = 17'd32768;
         6'd17: v = 17'd35980;
         6'd18: v = 17'd39161;
         6'd19: v = 17'd42280;
         6'd20: v = 17'd45308;
         6'd21: v = 17'd48215;
         6'd22: v = 17'd50973;
         6'd23: v = 17'd53556;
         6'd24: v = 17'd55938;
         6'd25: v = 17'd58098;
         6'd26: v = 17'd60014;
         6'd27: v = 17'd61667;
         6'd28: v = 17'd63042;
         6'd29: v = 17'd64125;
         6'd30: v = 17'd64906;
         6'd31: v = 17'd65378;
         default: v = 17'd65536;
      endcase
      return v;
   endfunction

   // Full window point 0..64, mirrored around the center.
   function automatic logic [16:0] hann_point(input logic [6:0] i);
      logic [6:0] j;
      j = (i > 7'd64) ? 7'd64 : i;
      return (j <= 7'd32) ? hann_half(j[5:0]) : hann_half(6'(7'd64 - j));
   endfunction

endpackage

@@ rtl/tgps_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module tgps_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/two_grain_pitch_shifter.sv @@
// Top level: two-grain delay-line pitch shifter with one shared multiplier.
//
// Usage
//   req channel: one mono sample per transaction with its target pitch ratio
//   (Q2.14) and target wet mix (Q1.15). rsp channel: one blended sample per
//   request transaction, in order. csr_wr_en/csr_wr_data load the one-pole
//   smoothing coefficient (Q0.16); write it only while the block is idle.
// Sequence
//   A processed sample steps through RATIO, WRITE, then RD0, RD1, S1, GS, WG
//   and ACC per grain, then MIX, MIXW, BLEND and RES; no new request is taken
//   before IDLE. The order is set by the single 28x18 multiplier, used nine
//   times per sample, and the one read port of the delay RAM (four reads per
//   sample). A bypassed sample (target and smoothed mix both below threshold)
//   returns the cycle after acceptance and leaves all state untouched.
// Reset
//   Synchronous, active high. After reset the delay RAM is zeroed one entry a
//   cycle, all BUFFER_DEPTH entries (2048 by default), with req_tready low.
// Backpressure
//   The result sits in an output register; a stalled receiver holds it there,
//   and a finished sample waits in its last step until the register is free.
// BUFFER_DEPTH and GRAIN_LENGTH must be powers of two.
module two_grain_pitch_shifter #(
   parameter int BUFFER_DEPTH = tgps_pkg::BUFFER_DEPTH_DEF,
   parameter int GRAIN_LENGTH = tgps_pkg::GRAIN_LENGTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // req_tdata: sample_in[23:0], target_ratio[39:24], wet_mix[55:40]
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [tgps_pkg::REQ_TDATA_W-1:0] req_tdata,
   // rsp_tdata: sample_out[23:0]
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [tgps_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                             csr_wr_en,
   input  logic [tgps_pkg::COEF_W-1:0]      csr_wr_data
);

   localparam int AW   = $clog2(BUFFER_DEPTH);
   localparam int LG   = $clog2(GRAIN_LENGTH);
   localparam int PH_W = LG + 16;            // phase: LG integer, 16 fraction bits
   localparam int WSH  = LG - 6;             // phase to 64-step window position
   localparam int RW   = (AW > LG) ? AW : LG;
   localparam logic [PH_W-1:0] PH_HALF = PH_W'(1) << (PH_W - 1);
   localparam logic [AW-1:0]   CLR_LAST = AW'(BUFFER_DEPTH - 1);

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_RATIO, ST_WRITE, ST_RD0, ST_RD1, ST_S1,
      ST_GS, ST_WG, ST_ACC, ST_MIX, ST_MIXW, ST_BLEND, ST_RES
   } state_type;

   state_type                   state_ff;
   logic [AW-1:0]               clr_cnt_ff;
   logic [tgps_pkg::COEF_W-1:0] coef_ff;
   logic [15:0]                 ratio_ff;
   logic [15:0]                 mixs_ff;
   logic [AW-1:0]               wp_ff;
   logic [PH_W-1:0]             ph_ff [2];
   logic                        grain_ff;
   logic signed [23:0]          dry_ff;
   logic [15:0]                 tgt_ff;
   logic [15:0]                 mixt_ff;
   logic signed [45:0]          mul_ff;
   logic signed [23:0]          s0_ff;
   logic [16:0]                 w_ff;
   logic signed [23:0]          gs_ff;
   logic signed [42:0]          acc_ff;
   logic signed [26:0]          wet_ff;
   logic                        rsp_valid_ff;
   logic [23:0]                 rsp_data_ff;

   // Request fields
   logic signed [23:0] req_sample;
   logic [15:0]        req_ratio;
   logic [15:0]        req_mix;
   logic [15:0]        req_mix_sat;
   logic               req_fire;
   logic               req_bypass;
   logic               out_free;

   assign req_sample  = signed'(req_tdata[23:0]);
   assign req_ratio   = req_tdata[39:24];
   assign req_mix     = req_tdata[55:40];
   assign req_mix_sat = (req_mix > tgps_pkg::MIX_FULL) ? tgps_pkg::MIX_FULL : req_mix;
   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign req_tready  = (state_ff == ST_IDLE) && out_free;
   assign req_fire    = req_tvalid && req_tready;
   assign req_bypass  = (req_mix_sat < tgps_pkg::MIX_THRESHOLD)
                        && (mixs_ff < tgps_pkg::MIX_THRESHOLD);

   // Current grain: window position and read addresses
   logic [PH_W-1:0]  cur_ph;
   logic [21:0]      win_pos;
   logic [16:0]      win_a;
   logic [16:0]      win_b;
   logic [LG-1:0]    pint;
   logic [15:0]      pfrac;
   logic [16:0]      f2;
   logic [RW-1:0]    r_full;
   logic [AW-1:0]    r0;
   logic [AW-1:0]    r1;

   assign cur_ph  = ph_ff[grain_ff];
   assign win_pos = 22'(cur_ph >> WSH);
   assign win_a   = tgps_pkg::hann_point({1'b0, win_pos[21:16]});
   assign win_b   = tgps_pkg::hann_point(7'({1'b0, win_pos[21:16]}) + 7'd1);
   assign pint    = cur_ph[PH_W-1:16];
   assign pfrac   = cur_ph[15:0];
   assign f2      = (pfrac == 16'd0) ? 17'd0 : 17'(17'h10000 - {1'b0, pfrac});
   assign r_full  = RW'(wp_ff) - RW'(pint) - RW'(pfrac != 16'd0);
   assign r0      = r_full[AW-1:0];
   assign r1      = r0 + AW'(1);

   // Delay RAM
   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [23:0]   ram_wdata;
   logic [AW-1:0] ram_raddr;
   logic [23:0]   ram_rdata;

   assign ram_we    = (state_ff == ST_CLEAR) || (state_ff == ST_WRITE);
   assign ram_waddr = (state_ff == ST_CLEAR) ? clr_cnt_ff : wp_ff;
   assign ram_wdata = (state_ff == ST_CLEAR) ? 24'd0 : dry_ff;
   assign ram_raddr = (state_ff == ST_RD1) ? r1 : r0;

   tgps_ram #(
      .WIDTH (tgps_pkg::SAMPLE_W),
      .DEPTH (BUFFER_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Shared multiplier operands
   logic signed [27:0] mul_a;
   logic signed [17:0] mul_b;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_RATIO: begin
            mul_a = 28'(signed'({1'b0, ratio_ff})) - 28'(signed'({1'b0, tgt_ff}));
            mul_b = signed'({2'b0, coef_ff});
         end
         ST_RD1: begin
            mul_a = 28'(signed'({1'b0, win_b})) - 28'(signed'({1'b0, win_a}));
            mul_b = signed'({2'b0, win_pos[15:0]});
         end
         ST_S1: begin
            mul_a = 28'(signed'(ram_rdata)) - 28'(s0_ff);
            mul_b = signed'({1'b0, f2});
         end
         ST_WG: begin
            mul_a = 28'(gs_ff);
            mul_b = signed'({1'b0, w_ff});
         end
         ST_MIX: begin
            mul_a = 28'(signed'({1'b0, mixs_ff})) - 28'(signed'({1'b0, mixt_ff}));
            mul_b = signed'({2'b0, coef_ff});
         end
         ST_BLEND: begin
            mul_a = 28'(wet_ff) - 28'(dry_ff);
            mul_b = signed'({2'b0, mixs_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Post-multiply sums
   logic signed [46:0] mul_ext;
   logic [15:0]        sm_tgt;
   logic signed [46:0] sm_sum;
   logic signed [46:0] win_sum;
   logic signed [46:0] int_sum;
   logic signed [42:0] acc_rnd;
   logic signed [46:0] res_sum;
   logic signed [31:0] res_val;
   logic [23:0]        res_sat;

   assign mul_ext = 47'(mul_ff);
   assign sm_tgt  = (state_ff == ST_MIXW) ? mixt_ff : tgt_ff;
   // a*y + (1-a)*t computed as a*(y-t) + t, rounded
   assign sm_sum  = mul_ext + signed'(47'({sm_tgt, 16'b0})) + 47'sd32768;
   assign win_sum = signed'(47'({win_a, 16'b0})) + mul_ext;
   assign int_sum = signed'({{7{s0_ff[23]}}, s0_ff, 16'b0}) + mul_ext + 47'sd32768;
   assign acc_rnd = acc_ff + 43'sd32768;
   assign res_sum = signed'({{8{dry_ff[23]}}, dry_ff, 15'b0}) + mul_ext + 47'sd16384;
   assign res_val = res_sum[46:15];
   assign res_sat = (res_val > 32'sd8388607)  ? 24'h7FFFFF :
                    (res_val < -32'sd8388608) ? 24'h800000 : res_val[23:0];

   // Output register load: bypassed sample or finished blend
   logic rsp_load;

   assign rsp_load = ((state_ff == ST_IDLE) && req_fire && req_bypass)
                     || ((state_ff == ST_RES) && out_free);

   // Sequencer, state and registered outputs
   always_ff @(posedge clock) begin
      mul_ff <= mul_a * mul_b;

      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         coef_ff      <= tgps_pkg::COEF_RESET;
         ratio_ff     <= tgps_pkg::RATIO_UNITY;
         mixs_ff      <= '0;
         wp_ff        <= '0;
         ph_ff[0]     <= PH_HALF;
         ph_ff[1]     <= '0;
         grain_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            coef_ff <= csr_wr_data;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_CLEAR: begin
               clr_cnt_ff <= clr_cnt_ff + AW'(1);
               if (clr_cnt_ff == CLR_LAST) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_fire) begin
                  if (req_bypass) begin
                     rsp_data_ff  <= req_sample;
                  end else begin
                     dry_ff   <= req_sample;
                     tgt_ff   <= req_ratio;
                     mixt_ff  <= req_mix_sat;
                     state_ff <= ST_RATIO;
                  end
               end
            end
            ST_RATIO: state_ff <= ST_WRITE;
            ST_WRITE: begin
               ratio_ff <= sm_sum[31:16];
               grain_ff <= 1'b0;
               acc_ff   <= '0;
               state_ff <= ST_RD0;
            end
            ST_RD0: state_ff <= ST_RD1;
            ST_RD1: begin
               s0_ff    <= signed'(ram_rdata);
               state_ff <= ST_S1;
            end
            ST_S1: begin
               w_ff     <= win_sum[32:16];
               state_ff <= ST_GS;
            end
            ST_GS: begin
               gs_ff    <= int_sum[39:16];
               state_ff <= ST_WG;
            end
            ST_WG: state_ff <= ST_ACC;
            ST_ACC: begin
               acc_ff          <= acc_ff + 43'(mul_ff);
               ph_ff[grain_ff] <= cur_ph + PH_W'({ratio_ff, 2'b0});
               if (grain_ff) begin
                  wp_ff    <= wp_ff + AW'(1);
                  state_ff <= ST_MIX;
               end else begin
                  grain_ff <= 1'b1;
                  state_ff <= ST_RD0;
               end
            end
            ST_MIX: begin
               wet_ff   <= acc_rnd[42:16];
               state_ff <= ST_MIXW;
            end
            ST_MIXW: begin
               mixs_ff  <= sm_sum[31:16];
               state_ff <= ST_BLEND;
            end
            ST_BLEND: state_ff <= ST_RES;
            ST_RES: begin
               if (out_free) begin
                  rsp_data_ff  <= res_sat;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

@@ rtl/tgps_checker.sv @@
// Checker on the pitch shifter ports, bound to the top level.
`include "two_grain_pitch_shifter_assert.svh"

module tgps_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic [tgps_pkg::REQ_TDATA_W-1:0] req_tdata,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [tgps_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   // A stalled result holds its data.
   `TGPS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "rsp dropped or changed under stall")

   // Ready only when the output register can take a bypassed sample.
   `TGPS_ASSERT_NOW(a_ready_slot, clock, reset, req_tready, !rsp_tvalid || rsp_tready, "req_tready with output register full")

   // After a transaction, either a bypass result shows or the block is busy.
   `TGPS_ASSERT_NEXT(a_busy_or_done, clock, reset, req_tvalid && req_tready, !req_tready || rsp_tvalid, "ready again without busy period or result")

endmodule

bind two_grain_pitch_shifter tgps_checker u_tgps_checker (.*);

@@ sim/two_grain_pitch_shifter_tb.sv @@
// Testbench for the two-grain pitch shifter: directed table plus random stream.
`timescale 1ns / 1ps

module two_grain_pitch_shifter_tb;

   localparam int DEPTH    = tgps_pkg::BUFFER_DEPTH_DEF;
   localparam int GRAIN    = tgps_pkg::GRAIN_LENGTH_DEF;
   localparam longint SPAN = longint'(GRAIN) << 16;
   localparam int N_RANDOM = 630;
   localparam longint CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [tgps_pkg::REQ_TDATA_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [tgps_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic csr_wr_en = 1'b0;
   logic [tgps_pkg::COEF_W-1:0] csr_wr_data = '0;

   always #10 clock = ~clock;

   two_grain_pitch_shifter dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   // One request transaction; exp_out >= 0 is a hand-typed expected sample.
   typedef struct {
      logic signed [tgps_pkg::SAMPLE_W-1:0] sample;
      logic [tgps_pkg::RATIO_W-1:0]         ratio;
      logic [tgps_pkg::MIX_W-1:0]           mix;
      int                                   exp_out;
   } shift_row_type;

   // Predictor state, mirrors the block's own.
   longint     pred_store[DEPTH];
   int         pred_wpos;
   longint     pred_phase[2];
   longint     pred_ratio;
   longint     pred_mix;
   longint     pred_coef;

   logic [tgps_pkg::SAMPLE_W-1:0] expected_samples[$];
   int     n_errors = 0;
   longint cycle_count = 0;
   bit     hold_off = 1'b0;   // long receiver stall request

   function automatic longint floor_shift(longint v, int n);
      return v >>> n;  // arithmetic shift on signed longint == floor
   endfunction

   function automatic longint hann_at(longint i);
      if (i > 64) i = 64;
      return tgps_pkg::hann_point(7'(i));
   endfunction

   function automatic longint window_gain(longint ph);
      longint pos, idx, f;
      pos = (ph * 64) / GRAIN;
      idx = pos >> 16;
      f = pos & 16'hFFFF;
      return (hann_at(idx) * (65536 - f) + hann_at(idx + 1) * f) >> 16;
   endfunction

   function automatic longint one_pole(longint y, longint target);
      return (pred_coef * y + (65536 - pred_coef) * target + 32768) >> 16;
   endfunction

   function automatic longint grain_tap(longint ph);
      longint pint, pfrac, r0, r1, f;
      pint = ph >> 16;
      pfrac = ph & 16'hFFFF;
      r0 = (pred_wpos + 2 * DEPTH - (pint % DEPTH) - (pfrac != 0 ? 1 : 0)) % DEPTH;
      r1 = (r0 + 1) % DEPTH;
      f = (pfrac != 0) ? 65536 - pfrac : 0;
      return floor_shift(pred_store[r0] * (65536 - f) + pred_store[r1] * f + 32768, 16);
   endfunction

   function automatic logic [tgps_pkg::SAMPLE_W-1:0] shift_sample(
         logic signed [tgps_pkg::SAMPLE_W-1:0] s,
         logic [tgps_pkg::RATIO_W-1:0] ratio,
         logic [tgps_pkg::MIX_W-1:0] mix_in);
      longint dry, mix, acc, wet, res, ph;
      dry = s;
      mix = (mix_in > tgps_pkg::MIX_FULL) ? tgps_pkg::MIX_FULL : mix_in;
      // bypass: both target and smoothed mix near zero, state untouched
      if (mix < tgps_pkg::MIX_THRESHOLD && pred_mix < tgps_pkg::MIX_THRESHOLD) return s;
      pred_ratio = one_pole(pred_ratio, ratio);
      pred_store[pred_wpos] = dry;
      acc = 0;
      for (int g = 0; g < 2; g++) begin
         ph = pred_phase[g] % SPAN;
         acc += window_gain(ph) * grain_tap(ph);
         pred_phase[g] = (ph + (pred_ratio << 2)) % SPAN;
      end
      wet = floor_shift(acc + 32768, 16);
      pred_wpos = (pred_wpos + 1) % DEPTH;
      pred_mix = one_pole(pred_mix, mix);
      res = floor_shift((32768 - pred_mix) * dry + pred_mix * wet + 16384, 15);
      if (res > 8388607) res = 8388607;
      if (res < -8388608) res = -8388608;
      return res[tgps_pkg::SAMPLE_W-1:0];
   endfunction

   task automatic send_sample(shift_row_type r);
      logic [tgps_pkg::SAMPLE_W-1:0] exp_s;
      int n;
      n = $urandom_range(0, 6);
      if (n != 0) begin
         req_tvalid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      exp_s = shift_sample(r.sample, r.ratio, r.mix);
      if (r.exp_out >= 0 && exp_s != tgps_pkg::SAMPLE_W'(r.exp_out)) begin
         $error("table sample_out: expected %0h, predictor %0h", r.exp_out, exp_s);
         n_errors++;
      end
      expected_samples.push_back(exp_s);
      req_tdata <= {r.mix, r.ratio, r.sample};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   // Wait until every result is back, plus a margin for the block to settle.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_coef(logic [tgps_pkg::COEF_W-1:0] v);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      pred_coef = v;
   endtask

   function automatic shift_row_type random_row();
      shift_row_type r;
      int k;
      r.sample = 24'($urandom());
      r.ratio = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(8192, 32768));
      k = $urandom_range(0, 9);
      if (k == 0) r.mix = 16'($urandom_range(0, 3));        // bypass region
      else if (k == 1) r.mix = 16'($urandom());             // above full too
      else r.mix = 16'($urandom_range(0, 32768));
      r.exp_out = -1;
      return r;
   endfunction

   // Receiver: random wait per transaction, plus a long hold-off on request.
   initial begin
      int n;
      @(negedge reset);
      forever begin
         if (hold_off) begin
            rsp_tready <= 1'b0;
            repeat (400) @(posedge clock);
            hold_off = 1'b0;
         end
         n = $urandom_range(0, 6);
         if (n != 0) begin
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Result checker.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_samples.size() == 0) begin
            $error("sample_out: unexpected transaction, actual %0h", rsp_tdata);
            n_errors++;
         end else begin
            logic [tgps_pkg::SAMPLE_W-1:0] e;
            e = expected_samples.pop_front();
            if (rsp_tdata !== e) begin
               $error("sample_out: expected %0h, actual %0h", e, rsp_tdata);
               n_errors++;
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   shift_row_type directed[$];
   shift_row_type row;
   logic [tgps_pkg::COEF_W-1:0] coef_plan[4] = '{16'd65535, 16'd0, 16'd32768,
                                                 tgps_pkg::COEF_RESET};

   initial begin
      for (int i = 0; i < DEPTH; i++) pred_store[i] = 0;
      pred_wpos = 0;
      pred_phase[0] = SPAN / 2;
      pred_phase[1] = 0;
      pred_ratio = tgps_pkg::RATIO_UNITY;
      pred_mix = 0;
      pred_coef = tgps_pkg::COEF_RESET;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Bypass rows also have hand-typed results; all use the predictor.
      directed.push_back('{24'sh7FFFFF, 16'd0, 16'd0, 24'h7FFFFF});
      directed.push_back('{24'sh800000, 16'hFFFF, 16'd3, 24'h800000});
      directed.push_back('{24'sh000001, 16'd16384, 16'd2, 24'h000001});
      directed.push_back('{24'sh7FFFFF, 16'd16384, 16'd32768, -1});
      directed.push_back('{24'sh800000, 16'hFFFF, 16'hFFFF, -1});
      directed.push_back('{24'sh7FFFFF, 16'd0, 16'd32768, -1});
      directed.push_back('{24'sh800000, 16'd65535, 16'd40000, -1});
      directed.push_back('{24'sh000000, 16'd8192, 16'd4, -1});
      directed.push_back('{24'sh555555, 16'hAAAA, 16'h5555, -1});
      directed.push_back('{24'shAAAAAA, 16'h5555, 16'hAAAA, -1});
      directed.push_back('{24'sh7FFFFF, 16'd32768, 16'd0, -1});
      directed.push_back('{24'sh800000, 16'd16384, 16'd1, -1});
      foreach (directed[i]) send_sample(directed[i]);
      drain();

      // Random part in phases, one coefficient setting per phase.
      for (int p = 0; p < 4; p++) begin
         write_coef(coef_plan[p]);
         for (int i = 0; i < N_RANDOM / 4; i++) begin
            if (p == 1 && i == 20) hold_off = 1'b1;
            row = random_row();
            send_sample(row);
         end
         drain();
      end

      if (n_errors == 0 && expected_samples.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/tgps_pkg.sv
rtl/tgps_ram.sv
rtl/two_grain_pitch_shifter.sv
rtl/tgps_checker.sv
sim/two_grain_pitch_shifter_tb.sv
